FILE: rtl/wnm_pkg.sv
// Shared constants, types and helpers of the wildcard name matcher.
package wnm_pkg;

  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned LEN_REG_W       = 6;
  localparam int unsigned PAT_WORDS       = 4;
  localparam int unsigned PAT_BYTES       = 32;
  localparam int unsigned DEF_MAX_PATTERN = 32;
  localparam int unsigned MID_DEPTH       = 2;
  localparam int unsigned OUT_DEPTH       = 4;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd4;

  typedef struct packed {
    logic present;
    logic last;
  } wnm_flags_t;

  // Map ASCII upper case to lower case, leave every other byte alone.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: rtl/wnm_fifo.sv
// Small generic queue with flop storage, used between front and back and at the result side.
module wnm_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       rd_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/wnm_front.sv
// Front end: takes input beats, drops idle ones, compares the character against every pattern byte.
module wnm_front import wnm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN
) (
  input  logic                     push_i,
  input  logic                     queue_full_i,
  input  logic [7:0]               name_char_i,
  input  wnm_flags_t               flags_i,
  input  logic [MAX_PATTERN*8-1:0] lit_i,
  output logic                     wr_o,
  output logic [MAX_PATTERN-1:0]   eq_o,
  output wnm_flags_t               flags_o
);

  logic [7:0] ch_fold;

  assign ch_fold = fold_case(name_char_i);

  // Beats with neither a character nor an end leave the state untouched: drop them here.
  assign wr_o    = push_i && !queue_full_i && (flags_i.present || flags_i.last);
  assign flags_o = flags_i;

  always_comb begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      eq_o[p] = (lit_i[p*8 +: 8] == ch_fold);
    end
  end

endmodule

FILE: rtl/wnm_back.sv
// Back end: holds the active position vector, advances it per character and resolves verdicts.
module wnm_back import wnm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int unsigned OUT_SLOTS   = OUT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  logic [MAX_PATTERN-1:0]            head_eq_i,
  input  wnm_flags_t                        head_flags_i,
  input  logic [MAX_PATTERN:0]              star_i,
  input  logic [MAX_PATTERN:0]              any_i,
  input  logic [MAX_PATTERN:0]              len_mask_i,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]  eff_len_i,
  input  logic [$clog2(OUT_SLOTS+1)-1:0]    out_cnt_i,
  output logic                              head_pop_o,
  output logic                              res_wr_o,
  output logic                              res_o
);

  localparam int unsigned N   = MAX_PATTERN + 1;
  localparam int unsigned LVL = $clog2(N);
  localparam int unsigned CW  = $clog2(OUT_SLOTS+1);

  // Close a set over runs of stars: a parallel prefix over (active, star-before) pairs.
  function automatic logic [N-1:0] close_stars(input logic [N-1:0] s,
                                               input logic [N-1:0] stars);
    logic [N-1:0] g;
    logic [N-1:0] pr;
    g  = s;
    pr = {stars[N-2:0], 1'b0};
    for (int l = 0; l < LVL; l++) begin
      g  = g | (pr & (g << (1 << l)));
      pr = pr & (pr << (1 << l));
    end
    return g;
  endfunction

  logic [N-1:0] act_q, act_d;
  logic [N-1:0] pend_vec_q, pend_vec_d;
  logic         pend_v_q, pend_v_d;
  logic [N-1:0] cur_closed, hit, step_vec, new_vec, pend_closed;
  logic         room, fire;

  assign cur_closed = close_stars(act_q, star_i);
  assign hit        = ({1'b0, head_eq_i} | any_i) & len_mask_i & ~star_i;
  assign step_vec   = (cur_closed & star_i) | {cur_closed[N-2:0] & hit[N-2:0], 1'b0};
  assign new_vec    = head_flags_i.present ? step_vec : act_q;

  // An ending beat needs a free result slot, counting the verdict still being resolved.
  assign room       = ((CW+1)'(out_cnt_i) + (CW+1)'(pend_v_q)) < (CW+1)'(OUT_SLOTS);
  assign fire       = head_valid_i && (!head_flags_i.last || room);
  assign head_pop_o = fire;

  always_comb begin
    act_d      = act_q;
    pend_vec_d = pend_vec_q;
    pend_v_d   = fire && head_flags_i.last;
    if (fire) begin
      pend_vec_d = new_vec;
      act_d      = head_flags_i.last ? N'(1) : new_vec;
    end
  end

  assign pend_closed = close_stars(pend_vec_q, star_i);
  assign res_wr_o    = pend_v_q;
  assign res_o       = pend_closed[eff_len_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= N'(1);
      pend_v_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_vec_q <= pend_vec_d;
  end

endmodule

FILE: rtl/wildcard_name_matcher.sv
// Top level of the wildcard name matcher: configuration, front, queues and back.
//
//  channel   direction  handshake           fields
//  input     in         push / full         name_char_i, char_present_i, name_end_i
//  result    out        empty / pop         matched_o
//  config    in         cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// One character per cycle while the back end does not stall; its active-vector update
// (star closure, step) sets that figure. A verdict goes through a pending register into
// the result queue. Reset clears the queues and the pattern registers and leaves only
// position 0 active. A full result queue stalls only ending beats in the back end; the
// front keeps filling its two-entry queue until that fills and raises full.
module wildcard_name_matcher import wnm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            name_char_i,
  input  logic                  char_present_i,
  input  logic                  name_end_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  matched_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned N    = MAX_PATTERN + 1;
  localparam int unsigned LENW = $clog2(MAX_PATTERN+1);
  localparam int unsigned MIDW = MAX_PATTERN + $bits(wnm_flags_t);
  localparam int unsigned OCW  = $clog2(OUT_DEPTH+1);

  logic [CFG_DATA_W-1:0]    pat_q [PAT_WORDS];
  logic [LEN_REG_W-1:0]     len_q;
  logic [LENW-1:0]          eff_len;
  logic [MAX_PATTERN*8-1:0] lit;
  logic [N-1:0]             star, any_m, len_mask;

  wnm_flags_t               in_flags, fr_flags, hd_flags;
  logic                     fr_wr;
  logic [MAX_PATTERN-1:0]   fr_eq, hd_eq;
  logic [MIDW-1:0]          hd_data;
  logic                     mid_full, mid_empty, mid_rd;
  logic                     res_wr, res_val, out_full;
  logic [OCW-1:0]           out_cnt;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_q[w] <= '0;
      end
      len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAT_LOW:    pat_q[0] <= cfg_wdata_i;
        REG_PAT_SECOND: pat_q[1] <= cfg_wdata_i;
        REG_PAT_THIRD:  pat_q[2] <= cfg_wdata_i;
        REG_PAT_HIGH:   pat_q[3] <= cfg_wdata_i;
        REG_PAT_LEN:    len_q    <= cfg_wdata_i[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len = (len_q > LEN_REG_W'(MAX_PATTERN)) ? LENW'(MAX_PATTERN) : LENW'(len_q);

  // Decode the pattern: positions past the stored bytes read as zero.
  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_pat
    logic [7:0] pbyte;
    if (p < PAT_BYTES) begin : g_stored
      assign pbyte = pat_q[p/8][(p%8)*8 +: 8];
    end else begin : g_blank
      assign pbyte = 8'h00;
    end
    assign lit[p*8 +: 8] = fold_case(pbyte);
    assign len_mask[p]   = (LENW'(p) < eff_len);
    assign star[p]       = len_mask[p] && (pbyte == STAR_CHAR);
    assign any_m[p]      = len_mask[p] && (pbyte == ANY_CHAR);
  end
  assign len_mask[MAX_PATTERN] = 1'b0;
  assign star[MAX_PATTERN]     = 1'b0;
  assign any_m[MAX_PATTERN]    = 1'b0;

  assign in_flags.present = char_present_i;
  assign in_flags.last    = name_end_i;

  wnm_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .push_i      (push),
    .queue_full_i(mid_full),
    .name_char_i (name_char_i),
    .flags_i     (in_flags),
    .lit_i       (lit),
    .wr_o        (fr_wr),
    .eq_o        (fr_eq),
    .flags_o     (fr_flags)
  );

  assign full = mid_full;

  wnm_fifo #(
    .WIDTH(MIDW),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fr_wr),
    .wdata_i({fr_eq, fr_flags}),
    .rd_i   (mid_rd),
    .rdata_o(hd_data),
    .full_o (mid_full),
    .empty_o(mid_empty),
    .count_o()
  );

  assign hd_eq    = hd_data[MIDW-1 -: MAX_PATTERN];
  assign hd_flags = wnm_flags_t'(hd_data[$bits(wnm_flags_t)-1:0]);

  wnm_back #(
    .MAX_PATTERN(MAX_PATTERN),
    .OUT_SLOTS  (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!mid_empty),
    .head_eq_i   (hd_eq),
    .head_flags_i(hd_flags),
    .star_i      (star),
    .any_i       (any_m),
    .len_mask_i  (len_mask),
    .eff_len_i   (eff_len),
    .out_cnt_i   (out_cnt),
    .head_pop_o  (mid_rd),
    .res_wr_o    (res_wr),
    .res_o       (res_val)
  );

  wnm_fifo #(
    .WIDTH(1),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_wr),
    .wdata_i(res_val),
    .rd_i   (pop),
    .rdata_o(matched_o),
    .full_o (out_full),
    .empty_o(empty),
    .count_o(out_cnt)
  );

  // A verdict must always find a free slot: the back end reserves it before it fires.
  a_no_result_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr |-> !out_full)
    else $error("verdict written into a full result queue");

  // Idle beats never reach the back end.
  a_idle_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !char_present_i && !name_end_i) |-> !fr_wr)
    else $error("idle beat entered the front queue");

  // Every ending beat taken by the back end yields exactly one verdict on the next cycle.
  a_verdict_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_rd && hd_flags.last) |=> res_wr)
    else $error("ending beat produced no verdict");

endmodule

FILE: test/wildcard_name_matcher_tb.sv
// Self-checking testbench for the wildcard name matcher: directed cases, then random names against random patterns.
`timescale 1ns / 1ps

module wildcard_name_matcher_tb;
  import wnm_pkg::*;

  localparam int MAXP = DEF_MAX_PATTERN;

  typedef struct {
    logic [7:0] ch;
    logic       present;
    logic       last;
  } name_beat_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  push           = 1'b0;
  logic                  full;
  logic [7:0]            name_char_i    = '0;
  logic                  char_present_i = 1'b0;
  logic                  name_end_i     = 1'b0;
  logic                  empty;
  logic                  pop            = 1'b0;
  logic                  matched_o;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;

  wildcard_name_matcher DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .name_char_i    (name_char_i),
    .char_present_i (char_present_i),
    .name_end_i     (name_end_i),
    .empty          (empty),
    .pop            (pop),
    .matched_o      (matched_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the block: pattern registers and live positions.
  logic [CFG_DATA_W-1:0] pat_word [PAT_WORDS];
  logic [LEN_REG_W-1:0]  len_reg;
  logic [MAXP:0]         live_pos;

  name_beat_t beat_q [$];
  logic       verdict_q [$];
  int         queued_cnt    = 0;
  int         accepted_cnt  = 0;
  int         results_seen  = 0;
  int         mismatch_cnt  = 0;
  int         phase_beats   = 0;
  bit         in_beat_seen  = 1'b0;
  bit         out_beat_seen = 1'b0;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic int eff_len();
    return (len_reg > MAXP) ? MAXP : int'(len_reg);
  endfunction

  function automatic logic [7:0] pat_at(input int p);
    return pat_word[p / 8][(p % 8) * 8 +: 8];
  endfunction

  function automatic logic [MAXP:0] close_star_runs(input logic [MAXP:0] s, input int n);
    for (int p = 0; p < n; p++) begin
      if (s[p] && pat_at(p) == STAR_CHAR) s[p + 1] = 1'b1;
    end
    return s;
  endfunction

  // Advance the live positions by one beat; returns 1 when a verdict is due.
  function automatic bit name_match_step(input name_beat_t b, output logic verdict);
    int            n;
    logic [MAXP:0] s;
    logic [MAXP:0] nxt;
    logic [7:0]    pc;
    n = eff_len();
    s = close_star_runs(live_pos, n);
    if (b.present) begin
      nxt = '0;
      for (int p = 0; p < n; p++) begin
        if (s[p]) begin
          pc = pat_at(p);
          if (pc == STAR_CHAR) nxt[p] = 1'b1;
          else if (pc == ANY_CHAR || to_lower(pc) == to_lower(b.ch)) nxt[p + 1] = 1'b1;
        end
      end
      live_pos = nxt;
      s = close_star_runs(live_pos, n);
    end
    verdict = s[n];
    if (b.last) live_pos = (MAXP + 1)'(1);
    return b.last;
  endfunction

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  // Letters of both cases, the bytes around the folding range, and plain random bytes.
  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 5))
      0, 1: return (8'h61 + 8'($urandom_range(0, 2))) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      2: begin
        case ($urandom_range(0, 7))
          0: return 8'h40;
          1: return 8'h5B;
          2: return 8'h60;
          3: return 8'h7B;
          4: return 8'h5A;
          5: return 8'h7A;
          6: return 8'h00;
          default: return 8'hFF;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_pattern_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) return (8'h61 + 8'($urandom_range(0, 2))) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    if (r < 11) return STAR_CHAR;
    if (r < 14) return ANY_CHAR;
    return pick_name_char();
  endfunction

  // Check results, then predict from the input beat.
  always @(posedge clk_i) begin
    name_beat_t seen;
    logic       verdict_bit;
    logic       exp_v;
    if (!rst_ni) begin
      in_beat_seen  = 1'b0;
      out_beat_seen = 1'b0;
    end else begin
      out_beat_seen = pop && !empty;
      if (out_beat_seen) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $error("matched: expected no result, got %0b", matched_o);
          mismatch_cnt++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (matched_o !== exp_v) begin
            $error("matched: expected %0b, got %0b", exp_v, matched_o);
            mismatch_cnt++;
          end
        end
      end
      in_beat_seen = push && !full;
      if (in_beat_seen) begin
        accepted_cnt++;
        seen.ch      = name_char_i;
        seen.present = char_present_i;
        seen.last    = name_end_i;
        if (name_match_step(seen, verdict_bit)) verdict_q.push_back(verdict_bit);
      end
    end
  end

  // Sender: hold a beat until taken, then idle for a drawn number of cycles.
  int         tx_wait  = 0;
  bit         tx_burst = 1'b0;
  name_beat_t tx_beat;

  always @(negedge clk_i) begin
    if (rst_ni && (!push || in_beat_seen)) begin
      if (push) tx_wait = draw_gap(tx_burst);
      if (tx_wait > 0 || beat_q.size() == 0) begin
        push <= 1'b0;
        if (tx_wait > 0) tx_wait--;
      end else begin
        tx_beat = beat_q.pop_front();
        push           <= 1'b1;
        name_char_i    <= tx_beat.ch;
        char_present_i <= tx_beat.present;
        name_end_i     <= tx_beat.last;
      end
    end
  end

  // Receiver: stall at random, and now and then for long enough to back the block up.
  int rx_wait      = 0;
  bit rx_burst     = 1'b0;
  int hold_cnt     = 0;
  int next_hold_at = 20;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_beat_seen) begin
        rx_wait = draw_gap(rx_burst);
        if (hold_cnt < 3 && results_seen >= next_hold_at && queued_cnt - accepted_cnt > 60) begin
          rx_wait = 300;
          hold_cnt++;
          next_hold_at = results_seen + 80;
        end
      end
      if (rx_wait > 0) begin
        pop <= 1'b0;
        rx_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic put_beat(input logic [7:0] ch, input logic present, input logic last);
    name_beat_t b;
    b.ch      = ch;
    b.present = present;
    b.last    = last;
    beat_q.push_back(b);
    queued_cnt++;
    if (present || last) phase_beats++;
  endtask

  // Wait for every beat to be taken and every verdict to arrive, then let the pipe empty.
  task automatic drain();
    while (accepted_cnt != queued_cnt) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= REG_PAT_HIGH) pat_word[idx[1:0]] = data;
    else if (idx == REG_PAT_LEN) len_reg = data[LEN_REG_W-1:0];
  endtask

  // Byte 0 of the pattern sits in bits 7:0; bytes past the length get random filler.
  task automatic load_pattern(input logic [PAT_BYTES*8-1:0] bytes, input logic [LEN_REG_W-1:0] n);
    for (int i = 0; i < PAT_BYTES; i++) begin
      if (i >= n) bytes[i * 8 +: 8] = 8'($urandom);
    end
    for (int i = 0; i < PAT_WORDS; i++) begin
      write_reg(CFG_IDX_W'(REG_PAT_LOW + i), bytes[i * CFG_DATA_W +: CFG_DATA_W]);
    end
    write_reg(REG_PAT_LEN, CFG_DATA_W'(n));
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_PAT_LEN + 1, 2 ** CFG_IDX_W - 1)),
                {$urandom, $urandom});
    end
  endtask

  // Build a name that mostly fits the pattern, sometimes damaged, sometimes pure noise.
  task automatic send_name(input bit close_it);
    logic [7:0] txt [$];
    logic [7:0] pc;
    int         n;
    int         k;
    bit         carry;
    n = eff_len();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 8)) txt.push_back(pick_name_char());
    end else begin
      for (int p = 0; p < n; p++) begin
        pc = pat_at(p);
        if (pc == STAR_CHAR) begin
          repeat ($urandom_range(0, 3)) txt.push_back(pick_name_char());
        end else if (pc == ANY_CHAR) begin
          txt.push_back(pick_name_char());
        end else if (to_lower(pc) >= 8'h61 && to_lower(pc) <= 8'h7A && $urandom_range(0, 1)) begin
          txt.push_back(pc ^ 8'h20);
        end else begin
          txt.push_back(pc);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, txt.size());
        case ($urandom_range(0, 2))
          0: if (k < txt.size()) txt[k] = pick_name_char();
          1: if (k < txt.size()) txt.delete(k);
          default: txt.insert(k, pick_name_char());
        endcase
      end
    end
    carry = close_it && txt.size() > 0 && $urandom_range(0, 1);
    foreach (txt[i]) begin
      if ($urandom_range(0, 9) == 0) put_beat(pick_name_char(), 1'b0, 1'b0);
      put_beat(txt[i], 1'b1, carry && i == txt.size() - 1);
    end
    if (close_it && !carry) put_beat(pick_name_char(), 1'b0, 1'b1);
  endtask

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    logic [PAT_BYTES*8-1:0] pat_bits;
    logic [LEN_REG_W-1:0]   plen;
    foreach (pat_word[i]) pat_word[i] = '0;
    len_reg  = '0;
    live_pos = (MAXP + 1)'(1);
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty pattern straight after reset: idle beat, empty name, zero byte.
    put_beat(8'h00, 1'b0, 1'b0);
    put_beat(8'hFF, 1'b0, 1'b1);
    put_beat(8'h00, 1'b1, 1'b1);
    drain();

    // Star, letter, any, zero literal, star.
    load_pattern({STAR_CHAR, 8'h00, ANY_CHAR, 8'h61, STAR_CHAR}, 6'd5);
    put_beat(8'h78, 1'b1, 1'b0);
    put_beat(8'h41, 1'b1, 1'b0);
    put_beat(8'hFF, 1'b1, 1'b0);
    put_beat(8'h00, 1'b1, 1'b1);
    put_beat(8'h00, 1'b0, 1'b1);
    put_beat(8'h5A, 1'b1, 1'b1);
    drain();

    // Length beyond the buffer saturates; all stars match anything.
    load_pattern({PAT_BYTES{STAR_CHAR}}, 6'h3F);
    put_beat(8'h00, 1'b0, 1'b1);
    put_beat(8'hFF, 1'b1, 1'b1);
    put_beat(8'h71, 1'b1, 1'b0);
    drain();

    // Swap the pattern halfway through a name.
    load_pattern({ANY_CHAR, 8'h51}, 6'd2);
    put_beat(8'h72, 1'b1, 1'b1);
    put_beat(8'h51, 1'b1, 1'b0);
    put_beat(8'h7A, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: plen = 6'd0;
        1: plen = 6'd1;
        2: plen = 6'd32;
        3: plen = 6'h3F;
        4: plen = 6'($urandom_range(33, 62));
        default: plen = 6'($urandom_range(2, 12));
      endcase
      for (int i = 0; i < PAT_BYTES; i++) pat_bits[i * 8 +: 8] = pick_pattern_char();
      load_pattern(pat_bits, plen);
      phase_beats = 0;
      while (phase_beats < 200) send_name(1'b1);
      // Leave a name open across the next reconfiguration now and then.
      if ($urandom_range(0, 1)) send_name(1'b0);
      drain();
    end

    drain();
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
